[rtl/pidl_pkg.sv]
// Shared types and constants for the positional insert/delete list.
// Holds request/result payload structs, status and mode codes, cell commands.
// No dependencies.
package pidl_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int SLOT_W    = 5;
  localparam int FILL_W    = 5;
  localparam int DEPTH_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_POSEMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [POS_W-1:0]   position;
    data_t              value;
  } in_t;

  typedef struct packed {
    status_t            status;
    data_t              data;
    logic [SLOT_W-1:0]  slot;
    logic [FILL_W-1:0]  fill;
    logic               last;
  } out_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } cell_cmd_t;

endpackage

[rtl/pidl_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Takes its neighbor's entry on insert/remove shifts. Depends on pidl_pkg.
module pidl_cell #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  pidl_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]       at,
  input  pidl_pkg::data_t     left,
  input  pidl_pkg::data_t     right,
  output pidl_pkg::data_t     q
);
  import pidl_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  data_t entry_r;
  data_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      OP_INSERT: begin
        if (MY_IDX > at) begin
          entry_nxt = left;
        end else if (MY_IDX == at) begin
          entry_nxt = cmd.value;
        end
      end
      OP_REMOVE: begin
        // close the gap: everything from the removed slot on moves down
        if (MY_IDX >= at) begin
          entry_nxt = right;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

[rtl/positional_insert_delete_list.sv]
// Positional insert/delete list: keeps up to DEPTH signed 32-bit entries packed
// from slot 1 in a chain of cells that shift in parallel. Insert, read and remove
// each take one request per cycle and give their result in the next cycle, held in an
// output register; the next request is taken in the cycle that result is taken
// (or if the output register is empty). List gives one result per occupied entry
// (a single empty-status result when the list is empty) through the single read
// select, one per cycle while the output is free, and takes no request until the last
// one is given. Entry storage has no reset. Depends on pidl_pkg and pidl_cell.
module positional_insert_delete_list #(
  parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pidl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pidl_pkg::out_t out_data
);
  import pidl_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(DEPTH);
  localparam logic [CW-1:0]    OCC_MAX = CW'(DEPTH);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [IW-1:0]   lst_idx_r, lst_idx_nxt;
  logic            out_valid_r;
  out_t            out_data_r;

  logic            out_free;
  logic            in_acc;
  logic            list_step;
  logic [IW-1:0]   rd_idx;
  data_t           rd_data;

  cell_cmd_t       cmd;
  logic [IW-1:0]   cmd_at;
  data_t           cell_q [DEPTH];

  out_t            res;
  out_t            lst_res;
  logic            lst_last;
  logic            list_start;
  logic            pos_ok;
  logic            full;
  logic            empty;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] occ_ext;
  logic [POS_W-1:0] at_ins;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_w;
    data_t right_w;
    if (i == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    pidl_cell #(.DEPTH(DEPTH), .IDX(i), .IW(IW)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .at    (cmd_at),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i])
    );
  end

  assign rd_data = cell_q[rd_idx];

  // ---------------- control FSM ----------------
  assign out_free  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign list_step = (state_r == S_LIST) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (list_start) state_nxt = S_LIST;
      S_LIST: if (list_step && lst_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_idx   = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_data.mode != MODE_LIST) rd_idx = pos_m1[IW-1:0];
      end
      S_LIST: rd_idx = lst_idx_r;
      default: in_ready = 1'b0;
    endcase
  end

  // ---------------- request decode ----------------
  assign pos_ok  = (in_data.position >= POS_W'(1)) && (in_data.position <= POS_MAX);
  assign full    = (occ_r >= OCC_MAX);
  assign empty   = (occ_r == '0);
  assign pos_m1  = in_data.position - POS_W'(1);
  assign occ_ext = POS_W'(occ_r);
  assign at_ins  = (pos_m1 > occ_ext) ? occ_ext : pos_m1;

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    cmd.op     = OP_HOLD;
    cmd.value  = in_data.value;
    cmd_at     = pos_m1[IW-1:0];
    occ_nxt    = occ_r;
    list_start = 1'b0;
    case (in_data.mode)
      MODE_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (!pos_ok) begin
          res.status = ST_BADPOS;
        end else begin
          cmd.op   = OP_INSERT;
          cmd_at   = at_ins[IW-1:0];
          occ_nxt  = occ_r + CW'(1);
          res.slot = SLOT_W'(at_ins + POS_W'(1));
        end
      end
      MODE_READ, MODE_REMOVE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (!pos_ok) begin
          res.status = ST_BADPOS;
        end else if (pos_m1 >= occ_ext) begin
          res.status = ST_POSEMPTY;
        end else begin
          res.data = rd_data;
          res.slot = SLOT_W'(in_data.position);
          if (in_data.mode == MODE_REMOVE) begin
            cmd.op  = OP_REMOVE;
            occ_nxt = occ_r - CW'(1);
          end
        end
      end
      MODE_LIST: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.data   = rd_data;
          res.slot   = SLOT_W'(1);
          res.last   = (occ_r == CW'(1));
          list_start = in_acc && !res.last;
        end
      end
      default: res.status = ST_OK;
    endcase
    if (!in_acc) begin
      cmd.op  = OP_HOLD;
      occ_nxt = occ_r;
    end
    res.fill = FILL_W'(occ_nxt);
  end

  // ---------------- list walk ----------------
  always_comb begin
    lst_last       = ((CW'(lst_idx_r) + CW'(1)) == occ_r);
    lst_res        = '0;
    lst_res.status = ST_OK;
    lst_res.data   = rd_data;
    lst_res.slot   = SLOT_W'(CW'(lst_idx_r) + CW'(1));
    lst_res.fill   = FILL_W'(occ_r);
    lst_res.last   = lst_last;
    lst_idx_nxt    = lst_idx_r;
    if (list_start) begin
      lst_idx_nxt = IW'(1);
    end else if (list_step) begin
      lst_idx_nxt = lst_idx_r + IW'(1);
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      lst_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      lst_idx_r <= lst_idx_nxt;
      if (in_acc || list_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end else if (list_step) begin
      out_data_r <= lst_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_MAX)
    else $error("fill count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_INSERT && res.status == ST_OK)
      |=> (occ_r == $past(occ_r) + CW'(1)))
    else $error("accepted insert did not grow the list");

  a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (CW'(lst_idx_r) < occ_r && !in_ready))
    else $error("list walk index out of range or request taken mid-walk");

endmodule

[test/positional_insert_delete_list_tb.sv]
// Testbench for positional_insert_delete_list: drives insert/read/remove/list requests
// and checks every result against a shadow copy of the list kept in the bench.
// Depends on pidl_pkg and the RTL of the list.
module positional_insert_delete_list_tb;
  import pidl_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 24;

  // Shadow of the list: predicts the results of each accepted request
  class list_shadow;
    data_t       entries [DEPTH];
    int unsigned fill_count;
    out_t        awaited[$];
    int unsigned errors;

    function new();
      fill_count = 0;
      errors     = 0;
    endfunction

    function void add_result(status_t st, data_t d, int unsigned slot_no, bit is_last);
      out_t r;
      r.status = st;
      r.data   = d;
      r.slot   = slot_no[SLOT_W-1:0];
      r.fill   = fill_count[FILL_W-1:0];
      r.last   = is_last;
      awaited.push_back(r);
    endfunction

    function void note_request(in_t req);
      bit          pos_ok;
      int unsigned at;
      pos_ok = (req.position >= 1) && (req.position <= DEPTH);
      case (req.mode)
        MODE_INSERT: begin
          if (fill_count >= DEPTH) begin
            add_result(ST_FULL, '0, 0, 1'b1);
          end else if (!pos_ok) begin
            add_result(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            at = req.position - 1;
            if (at > fill_count) at = fill_count;
            for (int i = fill_count; i > at; i--) entries[i] = entries[i-1];
            entries[at] = req.value;
            fill_count++;
            add_result(ST_OK, '0, at + 1, 1'b1);
          end
        end
        MODE_READ, MODE_REMOVE: begin
          if (fill_count == 0) begin
            add_result(ST_EMPTY, '0, 0, 1'b1);
          end else if (!pos_ok) begin
            add_result(ST_BADPOS, '0, 0, 1'b1);
          end else if (req.position > fill_count) begin
            add_result(ST_POSEMPTY, '0, 0, 1'b1);
          end else begin
            at = req.position - 1;
            if (req.mode == MODE_REMOVE) begin
              data_t taken;
              taken = entries[at];
              for (int i = at; i + 1 < fill_count; i++) entries[i] = entries[i+1];
              fill_count--;
              add_result(ST_OK, taken, at + 1, 1'b1);
            end else begin
              add_result(ST_OK, entries[at], at + 1, 1'b1);
            end
          end
        end
        default: begin
          if (fill_count == 0) begin
            add_result(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            for (int i = 0; i < fill_count; i++)
              add_result(ST_OK, entries[i], i + 1, (i + 1 == fill_count));
          end
        end
      endcase
    endfunction

    function void field_check(string fname, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, fname, want_v, got_v);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual 0x%h",
                 $time, got);
        return;
      end
      want = awaited.pop_front();
      field_check("status", want.status, got.status);
      field_check("data",   want.data,   got.data);
      field_check("slot",   want.slot,   got.slot);
      field_check("fill",   want.fill,   got.fill);
      field_check("last",   want.last,   got.last);
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bit rx_long_hold = 1'b0;
  bit rx_calm      = 1'b0;

  list_shadow shadow = new();

  positional_insert_delete_list i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold valid and payload until the request is taken
  task automatic send(input in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(req);
  endtask

  task automatic send_fields(input mode_t m, input int unsigned p, input data_t v);
    in_t req;
    req.mode     = m;
    req.position = p[POS_W-1:0];
    req.value    = v;
    send(req);
  endtask

  task automatic idle(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic data_t random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests for the current fill, with some noise
  function automatic in_t random_request(bit growing);
    in_t         req;
    int unsigned roll;
    int unsigned n;
    n         = shadow.fill_count;
    req.value = random_value();
    roll      = $urandom_range(0, 99);
    if (roll < 12) begin
      req.mode     = mode_t'($urandom_range(0, 3));
      req.position = POS_W'($urandom_range(0, 255));
    end else if (roll < 16) begin
      req.mode     = MODE_LIST;
      req.position = POS_W'($urandom_range(0, 255));
    end else if (roll < (growing ? 70 : 35)) begin
      req.mode     = MODE_INSERT;
      req.position = POS_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? DEPTH : n + 1));
    end else begin
      req.mode     = ($urandom_range(0, 2) < (growing ? 1 : 2)) ? MODE_REMOVE : MODE_READ;
      req.position = POS_W'($urandom_range(1, (n == 0) ? 1 : n));
    end
    return req;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(out_data);
  end

  initial begin : result_sink
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : request_source
    int unsigned k;
    bit          growing;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list cases
    send_fields(MODE_LIST,   0,   32'h0000_0001);
    send_fields(MODE_READ,   1,   '0);
    send_fields(MODE_REMOVE, 0,   '0);
    send_fields(MODE_INSERT, 0,   32'h1234_5678);
    send_fields(MODE_INSERT, 17,  32'h7fff_ffff);
    // past the end appends
    send_fields(MODE_INSERT, 5,   32'h8000_0000);
    send_fields(MODE_INSERT, 1,   '1);
    send_fields(MODE_INSERT, 2,   32'h7fff_ffff);
    send_fields(MODE_INSERT, 16,  '0);
    send_fields(MODE_READ,   0,   '0);
    send_fields(MODE_REMOVE, 255, '0);
    send_fields(MODE_READ,   5,   '0);
    send_fields(MODE_READ,   2,   '0);
    send_fields(MODE_REMOVE, 4,   '0);
    send_fields(MODE_REMOVE, 1,   '0);
    send_fields(MODE_LIST,   255, '0);
    for (k = 0; k < 14; k++) send_fields(MODE_INSERT, (k * 5) % DEPTH + 1, $urandom);
    // full list: position is not checked
    send_fields(MODE_INSERT, 0,   32'h5555_aaaa);
    send_fields(MODE_LIST,   3,   '0);
    send_fields(MODE_READ,   16,  '0);
    send_fields(MODE_REMOVE, 16,  '0);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      growing = ((k / 40) % 2) == 0;
      if (k == 100) rx_long_hold = 1'b1;
      if (k == 250) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (shadow.awaited.size() != 0);
      end
      if (k >= RANDOM_ITEMS - 60) rx_calm = 1'b1;
      send(random_request(growing));
      if (!rx_calm && !(k >= 100 && k < 140) && ((k / 25) % 3 != 2) &&
          $urandom_range(0, 3) == 0)
        idle($urandom_range(1, 12));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.awaited.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
      $display("positional_insert_delete_list verification clean");
    end else begin
      $display("positional_insert_delete_list verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("positional_insert_delete_list verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list.sv
test/positional_insert_delete_list_tb.sv
